[hdl/cspt_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Call stack path timer package
// Shared constants, item and frame types and the FNV-1a 64 mixing step.
// ============================================================================
package cspt_pkg;

   // Default number of frames held on chip.
   localparam int STACK_DEPTH_DEFAULT = 64;

   // Path hash start value (not the standard FNV-1a 64 offset basis) and FNV-1a 64 prime.
   localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

   // The lowest bit of a function id is ignored and read as zero.
   localparam logic [63:0] KIND_BIT = 64'd1;

   // Count of enters that found the stack full and still wait for a leave.
   localparam int          OVF_W   = 16;
   localparam logic [OVF_W-1:0] OVF_MAX = {OVF_W{1'b1}};

   // Width of the reported path depth.
   localparam int DEPTH_FIELD_W = 7;

   // Register port geometry and register indexes.
   localparam int          CSR_ADDR_W = 3;
   localparam int          CSR_DATA_W = 32;
   localparam logic [0:0]  REG_TRACE_ENABLE = 1'b0;

   // One trace event as held in the input register.
   typedef struct packed {
      logic        is_leave;
      logic [63:0] func_id;
      logic [63:0] timestamp;
   } event_type;

   // One stack frame.
   typedef struct packed {
      logic [63:0] func_id;
      logic [63:0] enter_time;
      logic [63:0] child_time;
      logic [63:0] prefix_hash;
   } frame_type;

   // One completed call.
   typedef struct packed {
      logic [63:0]              path_hash;
      logic [63:0]              inclusive_time;
      logic [63:0]              exclusive_time;
      logic [63:0]              leaf_function;
      logic [DEPTH_FIELD_W-1:0] path_depth;
   } result_type;

   // Stack status seen by the top level.
   typedef struct packed {
      logic empty;
      logic full;
      logic overflowed;
   } stack_status_type;

   // One FNV-1a 64 step: xor in the id, then multiply by the prime.
   // The prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
   function automatic logic [63:0] fnv_mix(input logic [63:0] hash,
                                           input logic [63:0] func_id);
      logic [63:0] x;
      x = hash ^ func_id;
      return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
   endfunction

endpackage

[hdl/cspt_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// Call stack path timer channels
// Valid/ready channels for trace events and for completed calls.
// ============================================================================

// Trace event channel.
interface cspt_req_if;
   logic        valid;
   logic        ready;
   logic        is_leave;
   logic [63:0] func_id;
   logic [63:0] timestamp;

   modport source (output valid, output is_leave, output func_id, output timestamp,
                   input ready);
   modport sink   (input valid, input is_leave, input func_id, input timestamp,
                   output ready);
endinterface

// Completed call channel.
interface cspt_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] path_hash;
   logic [63:0] inclusive_time;
   logic [63:0] exclusive_time;
   logic [63:0] leaf_function;
   logic [cspt_pkg::DEPTH_FIELD_W-1:0] path_depth;

   modport source (output valid, output path_hash, output inclusive_time,
                   output exclusive_time, output leaf_function, output path_depth,
                   input ready);
   modport sink   (input valid, input path_hash, input inclusive_time,
                   input exclusive_time, input leaf_function, input path_depth,
                   output ready);
endinterface

[hdl/call_stack_path_timer_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// Call stack path timer
// Bounded call stack profiler with 64-bit path hashes built from FNV-1a 64 mixing steps.
// ============================================================================
// The unit accepts one trace event per clock cycle and returns the completed
// call of each leave event that pops a frame, through the input register and
// then the result register. Throughput is set by the frame stack, which
// keeps the top frame in registers and prefetches the frame below it from a
// registered-read memory every cycle, so a push or a pop can follow in the
// very next cycle. The input side only stalls while the result register is
// full and the result is not taken. There is no clearing pass after reset;
// events are ignored until trace_enable is set.
module call_stack_path_timer_unit #(
   parameter int STACK_DEPTH = cspt_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   cspt_req_if.sink                        req,
   cspt_rsp_if.source                      rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cspt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cspt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cspt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic                       trace_enable;
   logic                       in_valid_ff, in_valid_in;
   cspt_pkg::event_type        in_ff;
   logic                       out_valid_ff, out_valid_in;
   cspt_pkg::result_type       out_ff;
   logic                       req_transfer;
   logic                       out_free;
   logic                       fire;
   logic                       emit;
   cspt_pkg::result_type       result;
   cspt_pkg::stack_status_type status;

   // Register port.
   cspt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .trace_enable (trace_enable)
   );

   // Handshake: the held event is processed when the result register is free.
   assign out_free     = !out_valid_ff || rsp.ready;
   assign fire         = in_valid_ff && out_free;
   assign req.ready    = !in_valid_ff || fire;
   assign req_transfer = req.valid && req.ready;

   // Input register.
   assign in_valid_in = req_transfer || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_ff.is_leave  <= req.is_leave;
         in_ff.func_id   <= req.func_id;
         in_ff.timestamp <= req.timestamp;
      end
   end

   // Stack update and completed call.
   cspt_frame_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .evt          (in_ff),
      .trace_enable (trace_enable),
      .emit         (emit),
      .result       (result),
      .status       (status)
   );

   // Result register.
   assign out_valid_in = (fire && emit) || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.path_hash      = out_ff.path_hash;
   assign rsp.inclusive_time = out_ff.inclusive_time;
   assign rsp.exclusive_time = out_ff.exclusive_time;
   assign rsp.leaf_function  = out_ff.leaf_function;
   assign rsp.path_depth     = out_ff.path_depth;

   // Enters are only counted as overflow once the stack is full.
   a_overflow_needs_full : assert property (@(posedge clock) disable iff (reset)
      status.overflowed |-> status.full)
      else $error("overflow count is set while the stack is not full");

   // A completed call reaches the result register in the next cycle.
   a_emit_reaches_output : assert property (@(posedge clock) disable iff (reset)
      (fire && emit) |=> rsp.valid)
      else $error("completed call did not reach the result register");

   // No completed call while tracing is off.
   a_no_emit_when_disabled : assert property (@(posedge clock) disable iff (reset)
      (fire && !trace_enable) |-> !emit)
      else $error("completed call produced while tracing is disabled");

   // A held event is never dropped before it is processed.
   a_event_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("held event lost before processing");

   // A call can only complete when there is a frame to pop.
   a_emit_needs_frame : assert property (@(posedge clock) disable iff (reset)
      (fire && emit) |-> !status.empty)
      else $error("completed call produced from an empty stack");

endmodule

[hdl/cspt_csr.sv]
`timescale 1ns / 1ps
// ============================================================================
// Call stack path timer register port
// APB-style access to the trace enable register.
// ============================================================================
module cspt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cspt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cspt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cspt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic                            trace_enable
);

   logic trace_enable_ff;
   logic trace_enable_in;
   logic wr_transfer;
   logic sel_trace_enable;

   // Register index is the top address bit; any address with it clear selects trace enable.
   assign sel_trace_enable = (paddr[cspt_pkg::CSR_ADDR_W-1] == cspt_pkg::REG_TRACE_ENABLE);
   assign pready           = 1'b1;
   assign wr_transfer      = psel && penable && pwrite && pready;

   // Write decode.
   always_comb begin
      trace_enable_in = trace_enable_ff;
      if (wr_transfer && sel_trace_enable) begin
         trace_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_enable_ff <= 1'b0;
      end else begin
         trace_enable_ff <= trace_enable_in;
      end
   end

   // Read decode.
   always_comb begin
      prdata = '0;
      if (sel_trace_enable) begin
         prdata = {{(cspt_pkg::CSR_DATA_W-1){1'b0}}, trace_enable_ff};
      end
   end

   assign trace_enable = trace_enable_ff;

endmodule

[hdl/cspt_frame_stack.sv]
`timescale 1ns / 1ps
// ============================================================================
// Call stack path timer frame stack
// Top frame in registers, lower frames in a memory with a prefetched read.
// ============================================================================
module cspt_frame_stack #(
   parameter int STACK_DEPTH = cspt_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  cspt_pkg::event_type        evt,
   input  logic                       trace_enable,
   output logic                       emit,
   output cspt_pkg::result_type       result,
   output cspt_pkg::stack_status_type status
);

   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int MEM_AW = $clog2(STACK_DEPTH);
   localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
   localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);
   localparam logic [LVL_W-1:0] LVL_TWO  = LVL_W'(2);
   localparam logic [cspt_pkg::OVF_W-1:0] OVF_ONE = {{(cspt_pkg::OVF_W-1){1'b0}}, 1'b1};

   logic [LVL_W-1:0]           level_ff, level_in;
   logic [cspt_pkg::OVF_W-1:0] ovf_ff, ovf_in;
   cspt_pkg::frame_type        tos_ff, tos_in;
   cspt_pkg::frame_type        nos_ff;
   cspt_pkg::frame_type        mem [STACK_DEPTH];

   logic              is_empty, is_full, is_overflowed;
   logic              wr_en;
   logic [MEM_AW-1:0] wr_addr, rd_addr;
   logic [63:0]       func_id;
   logic [63:0]       incl_time, excl_time, parent_child_time, push_hash;

   assign func_id       = evt.func_id & ~cspt_pkg::KIND_BIT;
   assign is_empty      = (level_ff == '0);
   assign is_full       = (level_ff == LVL_FULL);
   assign is_overflowed = (ovf_ff != '0);

   // Times of the popped frame and the parent's updated child time.
   assign incl_time         = evt.timestamp - tos_ff.enter_time;
   assign excl_time         = evt.timestamp - tos_ff.enter_time - tos_ff.child_time;
   assign parent_child_time = nos_ff.child_time + evt.timestamp - tos_ff.enter_time;

   // Path hash of a new frame extends the current top's prefix hash.
   assign push_hash = cspt_pkg::fnv_mix(is_empty ? cspt_pkg::FNV_BASIS : tos_ff.prefix_hash,
                                        func_id);

   // Event decode and next stack state.
   always_comb begin
      level_in = level_ff;
      ovf_in   = ovf_ff;
      tos_in   = tos_ff;
      emit     = 1'b0;
      wr_en    = 1'b0;
      if (step && trace_enable) begin
         if (!evt.is_leave) begin
            if (is_full || is_overflowed) begin
               if (ovf_ff != cspt_pkg::OVF_MAX) begin
                  ovf_in = ovf_ff + OVF_ONE;
               end
            end else begin
               // The old top moves down into the memory.
               wr_en              = !is_empty;
               tos_in.func_id     = func_id;
               tos_in.enter_time  = evt.timestamp;
               tos_in.child_time  = '0;
               tos_in.prefix_hash = push_hash;
               level_in           = level_ff + LVL_ONE;
            end
         end else if (is_overflowed) begin
            // A leave that matches an enter that was never pushed.
            ovf_in = ovf_ff - OVF_ONE;
         end else if (!is_empty) begin
            emit              = 1'b1;
            level_in          = level_ff - LVL_ONE;
            tos_in            = nos_ff;
            tos_in.child_time = parent_child_time;
         end
      end
   end

   // The memory holds frames below the top; nos_ff always holds the one just
   // below the top for the coming cycle.
   assign wr_addr = MEM_AW'(level_ff - LVL_ONE);
   assign rd_addr = MEM_AW'(level_in - LVL_TWO);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= tos_ff;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         nos_ff <= tos_ff;
      end else begin
         nos_ff <= mem[rd_addr];
      end
   end

   // Top frame holds payload only.
   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         ovf_ff   <= '0;
      end else begin
         level_ff <= level_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Completed call of the current top frame.
   assign result.path_hash      = tos_ff.prefix_hash;
   assign result.inclusive_time = incl_time;
   assign result.exclusive_time = excl_time;
   assign result.leaf_function  = tos_ff.func_id;
   assign result.path_depth     = cspt_pkg::DEPTH_FIELD_W'(level_ff);

   assign status.empty      = is_empty;
   assign status.full       = is_full;
   assign status.overflowed = is_overflowed;

endmodule
